[rtl/core/sic_pkg.sv]
// Shared relation codes for the segment intersection classifier.
package sic_pkg;
  localparam int REL_W = 2;
  localparam logic [REL_W-1:0] REL_DISJOINT = 2'd0;
  localparam logic [REL_W-1:0] REL_TOUCH    = 2'd1;
  localparam logic [REL_W-1:0] REL_OVERLAP  = 2'd2;
  localparam logic [REL_W-1:0] REL_CROSS    = 2'd3;
endpackage

[rtl/core/sic_prep.sv]
// Front pipeline: products, determinants, classification and divider setup.
module sic_prep #(
  parameter int CW = 16,
  parameter int F  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [8*CW-1:0]              in_data,
  output logic                         out_vld,
  output logic [2*CW+2:0]              out_d2,
  output logic [2*CW+2:0]              out_rx,
  output logic [2*CW+2:0]              out_ry,
  output logic [CW+F:0]                out_nx,
  output logic [CW+F:0]                out_ny,
  output logic [sic_pkg::REL_W+1+6*CW:0] out_side
);
  localparam int D   = CW + 1;
  localparam int PRW = 2 * D;
  localparam int DW  = 2 * CW + 3;
  localparam int UW  = 2 * CW + 2;
  localparam int RW  = UW + 1;
  localparam int QW  = CW + F + 1;
  localparam int MW  = CW + 1 + UW;
  localparam int NW  = MW + F + 2;

  // stage 1 inputs and combinational products
  logic signed [CW-1:0] x1s, y1s, x1e, y1e, x2s, y2s, x2e, y2e;
  logic signed [D-1:0] ax, ay, bx, by, cx, cy, ex, ey;
  logic signed [PRW-1:0] p_aybx, p_axby, p_bycx, p_bxcy, p_axcy, p_aycx, p_axey, p_ayex;

  assign x1s = in_data[0*CW +: CW];
  assign y1s = in_data[1*CW +: CW];
  assign x1e = in_data[2*CW +: CW];
  assign y1e = in_data[3*CW +: CW];
  assign x2s = in_data[4*CW +: CW];
  assign y2s = in_data[5*CW +: CW];
  assign x2e = in_data[6*CW +: CW];
  assign y2e = in_data[7*CW +: CW];

  always_comb begin
    ax = D'(x1e) - D'(x1s);
    ay = D'(y1e) - D'(y1s);
    bx = D'(x2s) - D'(x2e);
    by = D'(y2s) - D'(y2e);
    cx = D'(x1s) - D'(x2s);
    cy = D'(y1s) - D'(y2s);
    ex = D'(x2e) - D'(x1s);
    ey = D'(y2e) - D'(y1s);
    p_aybx = PRW'(ay) * PRW'(bx);
    p_axby = PRW'(ax) * PRW'(by);
    p_bycx = PRW'(by) * PRW'(cx);
    p_bxcy = PRW'(bx) * PRW'(cy);
    p_axcy = PRW'(ax) * PRW'(cy);
    p_aycx = PRW'(ay) * PRW'(cx);
    p_axey = PRW'(ax) * PRW'(ey);
    p_ayex = PRW'(ay) * PRW'(ex);
  end

  logic s1_vld, s1_anz, s1_bnz;
  logic signed [PRW-1:0] s1_aybx, s1_axby, s1_bycx, s1_bxcy, s1_axcy, s1_aycx, s1_axey, s1_ayex;
  logic signed [D-1:0] s1_ax, s1_ay;
  logic signed [CW-1:0] s1_px [4];
  logic signed [CW-1:0] s1_py [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_aybx <= p_aybx;
      s1_axby <= p_axby;
      s1_bycx <= p_bycx;
      s1_bxcy <= p_bxcy;
      s1_axcy <= p_axcy;
      s1_aycx <= p_aycx;
      s1_axey <= p_axey;
      s1_ayex <= p_ayex;
      s1_ax   <= ax;
      s1_ay   <= ay;
      s1_anz  <= (ax != '0) || (ay != '0);
      s1_bnz  <= (bx != '0) || (by != '0);
      s1_px[0] <= x1s;
      s1_py[0] <= y1s;
      s1_px[1] <= x1e;
      s1_py[1] <= y1e;
      s1_px[2] <= x2s;
      s1_py[2] <= y2s;
      s1_px[3] <= x2e;
      s1_py[3] <= y2e;
    end
  end

  // stage 2: determinants, extent test, middle two of the sorted endpoints
  logic signed [DW-1:0] den, na, nb, ce;
  logic ext_ok;
  logic [1:0] rank [4];
  logic signed [CW-1:0] m1x, m1y, m2x, m2y;
  logic signed [CW-1:0] x1lo, x1hi, x2lo, x2hi, y1lo, y1hi, y2lo, y2hi;

  always_comb begin
    den = DW'(s1_aybx) - DW'(s1_axby);
    na  = DW'(s1_bycx) - DW'(s1_bxcy);
    nb  = DW'(s1_axcy) - DW'(s1_aycx);
    ce  = DW'(s1_axey) - DW'(s1_ayex);
    x1lo = (s1_px[0] < s1_px[1]) ? s1_px[0] : s1_px[1];
    x1hi = (s1_px[0] < s1_px[1]) ? s1_px[1] : s1_px[0];
    x2lo = (s1_px[2] < s1_px[3]) ? s1_px[2] : s1_px[3];
    x2hi = (s1_px[2] < s1_px[3]) ? s1_px[3] : s1_px[2];
    y1lo = (s1_py[0] < s1_py[1]) ? s1_py[0] : s1_py[1];
    y1hi = (s1_py[0] < s1_py[1]) ? s1_py[1] : s1_py[0];
    y2lo = (s1_py[2] < s1_py[3]) ? s1_py[2] : s1_py[3];
    y2hi = (s1_py[2] < s1_py[3]) ? s1_py[3] : s1_py[2];
    ext_ok = !((x1hi < x2lo) || (x2hi < x1lo) || (y1hi < y2lo) || (y2hi < y1lo));
    for (int i = 0; i < 4; i++) begin
      rank[i] = 2'd0;
      for (int j = 0; j < 4; j++) begin
        if (j != i) begin
          if ((s1_px[j] < s1_px[i]) ||
              (s1_px[j] == s1_px[i] && s1_py[j] < s1_py[i]) ||
              (j < i && s1_px[j] == s1_px[i] && s1_py[j] == s1_py[i])) begin
            rank[i] = rank[i] + 2'd1;
          end
        end
      end
    end
    m1x = s1_px[0];
    m1y = s1_py[0];
    m2x = s1_px[0];
    m2y = s1_py[0];
    for (int i = 0; i < 4; i++) begin
      if (rank[i] == 2'd1) begin
        m1x = s1_px[i];
        m1y = s1_py[i];
      end
      if (rank[i] == 2'd2) begin
        m2x = s1_px[i];
        m2y = s1_py[i];
      end
    end
  end

  logic s2_vld, s2_anz, s2_bnz, s2_ext, s2_cez;
  logic signed [DW-1:0] s2_den, s2_na, s2_nb;
  logic signed [D-1:0] s2_ax, s2_ay;
  logic signed [CW-1:0] s2_x1s, s2_y1s, s2_m1x, s2_m1y, s2_m2x, s2_m2y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_den <= den;
      s2_na  <= na;
      s2_nb  <= nb;
      s2_cez <= (ce == '0);
      s2_anz <= s1_anz;
      s2_bnz <= s1_bnz;
      s2_ext <= ext_ok;
      s2_ax  <= s1_ax;
      s2_ay  <= s1_ay;
      s2_x1s <= s1_px[0];
      s2_y1s <= s1_py[0];
      s2_m1x <= m1x;
      s2_m1y <= m1y;
      s2_m2x <= m2x;
      s2_m2y <= m2y;
    end
  end

  // stage 3: classify, normalize sign of the denominator
  logic signed [DW-1:0] dd, nan, nbn;
  logic col, cross_ok;
  logic [sic_pkg::REL_W-1:0] rel;
  logic signed [D-1:0] axa, aya;

  always_comb begin
    dd  = s2_den[DW-1] ? -s2_den : s2_den;
    nan = s2_den[DW-1] ? -s2_na : s2_na;
    nbn = s2_den[DW-1] ? -s2_nb : s2_nb;
    cross_ok = !nan[DW-1] && (nan <= dd) && !nbn[DW-1] && (nbn <= dd);
    if (s2_anz) begin
      col = (s2_nb == '0) && s2_cez;
    end else if (s2_bnz) begin
      col = (s2_na == '0);
    end else begin
      col = 1'b1;
    end
    if (s2_den == '0) begin
      if (!col || !s2_ext) begin
        rel = sic_pkg::REL_DISJOINT;
      end else if (s2_m1x == s2_m2x && s2_m1y == s2_m2y) begin
        rel = sic_pkg::REL_TOUCH;
      end else begin
        rel = sic_pkg::REL_OVERLAP;
      end
    end else begin
      rel = cross_ok ? sic_pkg::REL_CROSS : sic_pkg::REL_DISJOINT;
    end
    axa = s2_ax[D-1] ? -s2_ax : s2_ax;
    aya = s2_ay[D-1] ? -s2_ay : s2_ay;
  end

  logic s3_vld, s3_negx, s3_negy;
  logic [sic_pkg::REL_W-1:0] s3_rel;
  logic [UW-1:0] s3_dd, s3_na;
  logic [CW:0] s3_axm, s3_aym;
  logic [6*CW-1:0] s3_pts;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_rel  <= rel;
      s3_dd   <= UW'(dd);
      s3_na   <= UW'(nan);
      s3_axm  <= (CW+1)'(axa);
      s3_aym  <= (CW+1)'(aya);
      s3_negx <= s2_ax[D-1];
      s3_negy <= s2_ay[D-1];
      s3_pts  <= {s2_x1s, s2_y1s, s2_m1x, s2_m1y, s2_m2x, s2_m2y};
    end
  end

  // stage 4: scale the numerator by the direction magnitudes
  logic s4_vld, s4_negx, s4_negy;
  logic [sic_pkg::REL_W-1:0] s4_rel;
  logic [UW-1:0] s4_dd;
  logic [MW-1:0] s4_mx, s4_my;
  logic [6*CW-1:0] s4_pts;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_mx   <= MW'(s3_axm) * MW'(s3_na);
      s4_my   <= MW'(s3_aym) * MW'(s3_na);
      s4_dd   <= s3_dd;
      s4_rel  <= s3_rel;
      s4_negx <= s3_negx;
      s4_negy <= s3_negy;
      s4_pts  <= s3_pts;
    end
  end

  // stage 5: rounded dividend, split into starting remainder and low bits
  logic [NW-1:0] nx, ny;

  always_comb begin
    nx = (NW'(s4_mx) << (F + 1)) + NW'(s4_dd) - NW'(s4_negx);
    ny = (NW'(s4_my) << (F + 1)) + NW'(s4_dd) - NW'(s4_negy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d2   <= {s4_dd, 1'b0};
      out_rx   <= RW'(nx >> QW);
      out_ry   <= RW'(ny >> QW);
      out_nx   <= nx[QW-1:0];
      out_ny   <= ny[QW-1:0];
      out_side <= {s4_rel, s4_negx, s4_negy, s4_pts};
    end
  end
endmodule

[rtl/core/sic_div_cell.sv]
// One restoring-division cell: yields one quotient bit for the x and y lanes.
module sic_div_cell #(
  parameter int RW = 35,
  parameter int QW = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [RW-1:0] in_d2,
  input  logic [RW-1:0] in_rx,
  input  logic [RW-1:0] in_ry,
  input  logic [QW-1:0] in_nx,
  input  logic [QW-1:0] in_ny,
  input  logic [QW-1:0] in_qx,
  input  logic [QW-1:0] in_qy,
  output logic          out_vld,
  output logic [RW-1:0] out_d2,
  output logic [RW-1:0] out_rx,
  output logic [RW-1:0] out_ry,
  output logic [QW-1:0] out_nx,
  output logic [QW-1:0] out_ny,
  output logic [QW-1:0] out_qx,
  output logic [QW-1:0] out_qy
);
  logic [RW:0] tx, ty, dv;
  logic gex, gey;

  always_comb begin
    dv  = {1'b0, in_d2};
    tx  = {in_rx, in_nx[QW-1]};
    ty  = {in_ry, in_ny[QW-1]};
    gex = (tx >= dv);
    gey = (ty >= dv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d2 <= in_d2;
      out_rx <= gex ? RW'(tx - dv) : RW'(tx);
      out_ry <= gey ? RW'(ty - dv) : RW'(ty);
      out_nx <= {in_nx[QW-2:0], 1'b0};
      out_ny <= {in_ny[QW-2:0], 1'b0};
      out_qx <= {in_qx[QW-2:0], gex};
      out_qy <= {in_qy[QW-2:0], gey};
    end
  end
endmodule

[rtl/core/segment_intersection_classify.sv]
// Segment intersection classifier top level: prep pipeline, divider cell row, output skid.
// Takes one segment pair per cycle while s_axis_tready is high and returns one word per
// pair, in order. The path is five front stages, one divider cell per quotient bit
// (COORD_BITS+FRAC_BITS+1 cells) and the output register. A stalled output holds one
// word in the output register and one in a skid register before input stalls.
module segment_intersection_classify #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
  // seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y
  input  logic [8*COORD_BITS-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // first_x, first_y, second_x, second_y, zero pad
  output logic [((4*(COORD_BITS+FRAC_BITS)+7)/8)*8-1:0] m_axis_tdata,
  // relation
  output logic [sic_pkg::REL_W-1:0] m_axis_tuser
);
  localparam int CW = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = CW + F;
  localparam int RW = 2 * CW + 3;
  localparam int QW = CW + F + 1;
  localparam int SW = sic_pkg::REL_W + 2 + 6 * CW;
  localparam int OW = ((4 * PW + 7) / 8) * 8;

  logic en;
  logic skid_vld;

  assign en = !skid_vld;
  assign s_axis_tready = !skid_vld;

  logic          c_vld [QW+1];
  logic [RW-1:0] c_d2 [QW+1];
  logic [RW-1:0] c_rx [QW+1];
  logic [RW-1:0] c_ry [QW+1];
  logic [QW-1:0] c_nx [QW+1];
  logic [QW-1:0] c_ny [QW+1];
  logic [QW-1:0] c_qx [QW+1];
  logic [QW-1:0] c_qy [QW+1];
  logic [SW-1:0] side [QW+1];

  sic_prep #(.CW(CW), .F(F)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s_axis_tvalid && s_axis_tready),
    .in_data  (s_axis_tdata),
    .out_vld  (c_vld[0]),
    .out_d2   (c_d2[0]),
    .out_rx   (c_rx[0]),
    .out_ry   (c_ry[0]),
    .out_nx   (c_nx[0]),
    .out_ny   (c_ny[0]),
    .out_side (side[0])
  );

  assign c_qx[0] = '0;
  assign c_qy[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    sic_div_cell #(.RW(RW), .QW(QW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (c_vld[i]),
      .in_d2   (c_d2[i]),
      .in_rx   (c_rx[i]),
      .in_ry   (c_ry[i]),
      .in_nx   (c_nx[i]),
      .in_ny   (c_ny[i]),
      .in_qx   (c_qx[i]),
      .in_qy   (c_qy[i]),
      .out_vld (c_vld[i+1]),
      .out_d2  (c_d2[i+1]),
      .out_rx  (c_rx[i+1]),
      .out_ry  (c_ry[i+1]),
      .out_nx  (c_nx[i+1]),
      .out_ny  (c_ny[i+1]),
      .out_qx  (c_qx[i+1]),
      .out_qy  (c_qy[i+1])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        side[i+1] <= side[i];
      end
    end
  end

  // assemble the result word
  logic [sic_pkg::REL_W-1:0] r_rel;
  logic r_negx, r_negy;
  logic signed [CW-1:0] r_bx, r_by, r_m1x, r_m1y, r_m2x, r_m2y;
  logic signed [PW-1:0] offx, offy, fx, fy, sx, sy;
  logic [4*PW-1:0] res_data;
  logic res_vld;

  assign res_vld = c_vld[QW];

  always_comb begin
    {r_rel, r_negx, r_negy, r_bx, r_by, r_m1x, r_m1y, r_m2x, r_m2y} = side[QW];
    offx = r_negx ? -PW'(c_qx[QW]) : PW'(c_qx[QW]);
    offy = r_negy ? -PW'(c_qy[QW]) : PW'(c_qy[QW]);
    fx = '0;
    fy = '0;
    sx = '0;
    sy = '0;
    case (r_rel)
      sic_pkg::REL_CROSS: begin
        fx = (PW'(r_bx) <<< F) + offx;
        fy = (PW'(r_by) <<< F) + offy;
      end
      sic_pkg::REL_TOUCH: begin
        fx = PW'(r_m1x) <<< F;
        fy = PW'(r_m1y) <<< F;
      end
      sic_pkg::REL_OVERLAP: begin
        fx = PW'(r_m1x) <<< F;
        fy = PW'(r_m1y) <<< F;
        sx = PW'(r_m2x) <<< F;
        sy = PW'(r_m2y) <<< F;
      end
      default: begin
        fx = '0;
      end
    endcase
    res_data = {sy, sx, fy, fx};
  end

  // output register with skid
  logic out_free, load_skid;
  logic [4*PW-1:0] m_data, skid_data;
  logic [sic_pkg::REL_W-1:0] m_rel, skid_rel;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign load_skid = !out_free && res_vld && !skid_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      if (out_free) begin
        m_axis_tvalid <= skid_vld || res_vld;
        skid_vld <= 1'b0;
      end else if (load_skid) begin
        skid_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      m_data <= skid_vld ? skid_data : res_data;
      m_rel  <= skid_vld ? skid_rel : r_rel;
    end
    if (load_skid) begin
      skid_data <= res_data;
      skid_rel  <= r_rel;
    end
  end

  assign m_axis_tdata = OW'(m_data);
  assign m_axis_tuser = m_rel;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> m_axis_tvalid)
    else $error("skid word held while output empty");

  a_disjoint_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == sic_pkg::REL_DISJOINT) |-> (m_axis_tdata == '0))
    else $error("disjoint word carries nonzero points");

  a_second_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != sic_pkg::REL_OVERLAP) |-> (m_data[4*PW-1:2*PW] == '0))
    else $error("second point set outside overlap");

  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready && !skid_vld && res_vld) |=> skid_vld)
    else $error("result dropped while output stalled");
endmodule
